/* rtl/tvna_pkg.sv */
// tvna_pkg: widths, command and state codes, datapath control struct
// and the saturating average used by the triangle vertex normal averager.
// No dependencies.
`default_nettype none

package tvna_pkg;

  // store sizes
  localparam int VERTEX_COUNT = 1024;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(VERTEX_COUNT);

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int NORM_W = 36;

  // cross product datapath widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int FACE_W = PROD_W + 1;
  localparam int SUM_W  = ((FACE_W > NORM_W) ? FACE_W : NORM_W) + 1;

  // packed memory words, x in the low lane
  localparam int POS_WORD_W = 3 * COORD_BITS;
  localparam int NRM_WORD_W = 3 * NORM_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_VERT  = 2'd0,
    CMD_WR_NORM  = 2'd1,
    CMD_TRIANGLE = 2'd2,
    CMD_RD_NORM  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_B,
    ST_RD_C,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_FACE,
    ST_UPD_A,
    ST_UPD_B,
    ST_UPD_C,
    ST_READ
  } state_t;

  // stage enables for the face normal datapath
  typedef struct packed {
    logic cap_a;
    logic cap_b;
    logic diff;
    logic mul1;
    logic mul2;
    logic face;
  } face_ctl_t;

  // index within the store
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return (32'(idx) < VERTEX_COUNT);
  endfunction

  // index to memory address, zero-extended or truncated
  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  // floor((old + face) / 2), saturated to the normal range
  function automatic logic [NORM_W-1:0] avg_sat(input logic [NORM_W-1:0] old_v,
                                                input logic [FACE_W-1:0] face_v);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-2:0] half;
    logic             ovf;
    sum  = {{(SUM_W-NORM_W){old_v[NORM_W-1]}}, old_v}
         + {{(SUM_W-FACE_W){face_v[FACE_W-1]}}, face_v};
    half = sum[SUM_W-1:1];
    ovf  = !(&half[SUM_W-2:NORM_W-1]) && (|half[SUM_W-2:NORM_W-1]);
    if (!ovf) begin
      return half[NORM_W-1:0];
    end else if (half[SUM_W-2]) begin
      return {1'b1, {(NORM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(NORM_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/tvna_ram.sv */
// tvna_ram: generic single-write, single-read memory with registered read.
// No dependencies.
`default_nettype none

module tvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/tvna_face.sv */
// tvna_face: face normal datapath, edge differences and the cross product
// (b-a) x (c-a) on three shared multipliers, a mul1 pass then a mul2 pass.
// Depends on tvna_pkg.
`default_nettype none

module tvna_face (
  input  logic                                   clk,
  input  tvna_pkg::face_ctl_t                    ctl,
  input  logic [tvna_pkg::POS_WORD_W-1:0]        pos_rdata,
  output logic signed [tvna_pkg::FACE_W-1:0]     face_x,
  output logic signed [tvna_pkg::FACE_W-1:0]     face_y,
  output logic signed [tvna_pkg::FACE_W-1:0]     face_z
);

  import tvna_pkg::*;

  logic [COORD_BITS-1:0] pos_x, pos_y, pos_z;
  logic [COORD_BITS-1:0] pa_x_r, pa_y_r, pa_z_r;
  logic [COORD_BITS-1:0] pb_x_r, pb_y_r, pb_z_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [DIFF_W-1:0] opa_x, opb_x, opa_y, opb_y, opa_z, opb_z;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [PROD_W-1:0] m1_x_r, m1_y_r, m1_z_r;
  logic signed [PROD_W-1:0] m2_x_r, m2_y_r, m2_z_r;
  logic signed [FACE_W-1:0] face_x_r, face_y_r, face_z_r;

  assign pos_x = pos_rdata[COORD_BITS-1:0];
  assign pos_y = pos_rdata[2*COORD_BITS-1:COORD_BITS];
  assign pos_z = pos_rdata[3*COORD_BITS-1:2*COORD_BITS];

  // capture vertex a and b positions
  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      pa_x_r <= pos_x;
      pa_y_r <= pos_y;
      pa_z_r <= pos_z;
    end
    if (ctl.cap_b) begin
      pb_x_r <= pos_x;
      pb_y_r <= pos_y;
      pb_z_r <= pos_z;
    end
  end

  // edge vectors u = b-a, v = c-a (c comes straight off the read port)
  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      ux_r <= {pb_x_r[COORD_BITS-1], pb_x_r} - {pa_x_r[COORD_BITS-1], pa_x_r};
      uy_r <= {pb_y_r[COORD_BITS-1], pb_y_r} - {pa_y_r[COORD_BITS-1], pa_y_r};
      uz_r <= {pb_z_r[COORD_BITS-1], pb_z_r} - {pa_z_r[COORD_BITS-1], pa_z_r};
      vx_r <= {pos_x[COORD_BITS-1], pos_x} - {pa_x_r[COORD_BITS-1], pa_x_r};
      vy_r <= {pos_y[COORD_BITS-1], pos_y} - {pa_y_r[COORD_BITS-1], pa_y_r};
      vz_r <= {pos_z[COORD_BITS-1], pos_z} - {pa_z_r[COORD_BITS-1], pa_z_r};
    end
  end

  // operand select: first pass positive terms, second pass negative terms
  always_comb begin
    if (ctl.mul1) begin
      opa_x = uy_r;  opb_x = vz_r;
      opa_y = uz_r;  opb_y = vx_r;
      opa_z = ux_r;  opb_z = vy_r;
    end else begin
      opa_x = uz_r;  opb_x = vy_r;
      opa_y = ux_r;  opb_y = vz_r;
      opa_z = uy_r;  opb_z = vx_r;
    end
  end

  assign prod_x = opa_x * opb_x;
  assign prod_y = opa_y * opb_y;
  assign prod_z = opa_z * opb_z;

  // product registers
  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      m1_x_r <= prod_x;
      m1_y_r <= prod_y;
      m1_z_r <= prod_z;
    end
    if (ctl.mul2) begin
      m2_x_r <= prod_x;
      m2_y_r <= prod_y;
      m2_z_r <= prod_z;
    end
  end

  // face normal
  always_ff @(posedge clk) begin
    if (ctl.face) begin
      face_x_r <= {m1_x_r[PROD_W-1], m1_x_r} - {m2_x_r[PROD_W-1], m2_x_r};
      face_y_r <= {m1_y_r[PROD_W-1], m1_y_r} - {m2_y_r[PROD_W-1], m2_y_r};
      face_z_r <= {m1_z_r[PROD_W-1], m1_z_r} - {m2_z_r[PROD_W-1], m2_z_r};
    end
  end

  assign face_x = face_x_r;
  assign face_y = face_y_r;
  assign face_z = face_z_r;

endmodule

`default_nettype wire

/* rtl/triangle_vertex_normal_averager.sv */
// triangle_vertex_normal_averager: top level with the command sequencer,
// the position and normal memories and the result register.
// Depends on tvna_pkg, tvna_ram and tvna_face.
`default_nettype none

// Keeps vertex positions and per-vertex normals in two single-write,
// single-read memories. After reset the normal memory is zeroed by a
// clearing pass over all VERTEX_COUNT (1024) entries while in_ready is low.
// One command at a time: a vertex or normal write is done on acceptance, a
// normal read waits in ST_READ while the result register is full, and a
// triangle runs three position reads on the one read port, the edge
// differences, two passes through three shared multipliers, the face
// subtraction, then three read-modify-write updates of the normal memory,
// the b and c reads overlapping the previous write, with forwarding when
// consecutive vertex indices repeat. Out-of-range writes and triangles are
// dropped; an out-of-range read returns a zero normal.

module triangle_vertex_normal_averager (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tvna_pkg::CMD_W-1:0]          in_command,
  input  logic [tvna_pkg::IDX_W-1:0]          in_index_a,
  input  logic [tvna_pkg::IDX_W-1:0]          in_index_b,
  input  logic [tvna_pkg::IDX_W-1:0]          in_index_c,
  input  logic signed [tvna_pkg::NORM_W-1:0]  in_value_x,
  input  logic signed [tvna_pkg::NORM_W-1:0]  in_value_y,
  input  logic signed [tvna_pkg::NORM_W-1:0]  in_value_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tvna_pkg::NORM_W-1:0]  out_normal_x,
  output logic signed [tvna_pkg::NORM_W-1:0]  out_normal_y,
  output logic signed [tvna_pkg::NORM_W-1:0]  out_normal_z
);

  import tvna_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] idx_a_r, idx_a_nxt;
  logic [ADDR_W-1:0] idx_b_r, idx_b_nxt;
  logic [ADDR_W-1:0] idx_c_r, idx_c_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [NRM_WORD_W-1:0] fwd_r, fwd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NRM_WORD_W-1:0] out_data_r, out_data_nxt;

  logic              accept;
  cmd_t              cmd;
  logic              ok_a, ok_b, ok_c;

  logic                  pos_we, pos_re;
  logic [ADDR_W-1:0]     pos_waddr, pos_raddr;
  logic [POS_WORD_W-1:0] pos_wdata, pos_rdata;
  logic                  nrm_we, nrm_re;
  logic [ADDR_W-1:0]     nrm_waddr, nrm_raddr;
  logic [NRM_WORD_W-1:0] nrm_wdata, nrm_rdata;

  face_ctl_t                ctl;
  logic signed [FACE_W-1:0] face_x, face_y, face_z;
  logic [NRM_WORD_W-1:0]    old_nrm, new_nrm;

  assign cmd    = cmd_t'(in_command);
  assign ok_a   = idx_ok(in_index_a);
  assign ok_b   = idx_ok(in_index_b);
  assign ok_c   = idx_ok(in_index_c);
  assign accept = in_valid && in_ready;

  // averaged normal for the vertex being updated
  assign new_nrm = {avg_sat(old_nrm[3*NORM_W-1:2*NORM_W], face_z),
                    avg_sat(old_nrm[2*NORM_W-1:NORM_W],   face_y),
                    avg_sat(old_nrm[NORM_W-1:0],          face_x)};

  // position memory write data, low coordinate bits of each value
  assign pos_wdata = {in_value_z[COORD_BITS-1:0], in_value_y[COORD_BITS-1:0],
                      in_value_x[COORD_BITS-1:0]};

  // sequencer: next state, memory ports and datapath enables
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    idx_c_nxt     = idx_c_r;
    rd_ok_nxt     = rd_ok_r;
    fwd_nxt       = fwd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    pos_we        = 1'b0;
    pos_waddr     = to_addr(in_index_a);
    pos_re        = 1'b0;
    pos_raddr     = to_addr(in_index_a);
    nrm_we        = 1'b0;
    nrm_waddr     = to_addr(in_index_a);
    nrm_wdata     = {in_value_z, in_value_y, in_value_x};
    nrm_re        = 1'b0;
    nrm_raddr     = to_addr(in_index_a);
    old_nrm       = nrm_rdata;
    ctl           = '0;

    case (state_r)
      ST_CLEAR: begin
        nrm_we      = 1'b1;
        nrm_waddr   = clr_cnt_r;
        nrm_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(VERTEX_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        idx_a_nxt = to_addr(in_index_a);
        idx_b_nxt = to_addr(in_index_b);
        idx_c_nxt = to_addr(in_index_c);
        if (accept) begin
          case (cmd)
            CMD_WR_VERT: begin
              pos_we = ok_a;
            end
            CMD_WR_NORM: begin
              nrm_we = ok_a;
            end
            CMD_TRIANGLE: begin
              if (ok_a && ok_b && ok_c) begin
                pos_re    = 1'b1;
                state_nxt = ST_RD_B;
              end
            end
            CMD_RD_NORM: begin
              nrm_re    = ok_a;
              rd_ok_nxt = ok_a;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD_B: begin
        pos_re    = 1'b1;
        pos_raddr = idx_b_r;
        ctl.cap_a = 1'b1;
        state_nxt = ST_RD_C;
      end
      ST_RD_C: begin
        pos_re    = 1'b1;
        pos_raddr = idx_c_r;
        ctl.cap_b = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        ctl.diff  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        ctl.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.mul2  = 1'b1;
        state_nxt = ST_FACE;
      end
      ST_FACE: begin
        ctl.face  = 1'b1;
        nrm_re    = 1'b1;
        nrm_raddr = idx_a_r;
        state_nxt = ST_UPD_A;
      end
      ST_UPD_A: begin
        nrm_we    = 1'b1;
        nrm_waddr = idx_a_r;
        nrm_wdata = new_nrm;
        fwd_nxt   = new_nrm;
        nrm_re    = 1'b1;
        nrm_raddr = idx_b_r;
        state_nxt = ST_UPD_B;
      end
      ST_UPD_B: begin
        // b was read while a was written
        if (idx_b_r == idx_a_r) begin
          old_nrm = fwd_r;
        end
        nrm_we    = 1'b1;
        nrm_waddr = idx_b_r;
        nrm_wdata = new_nrm;
        fwd_nxt   = new_nrm;
        nrm_re    = 1'b1;
        nrm_raddr = idx_c_r;
        state_nxt = ST_UPD_C;
      end
      ST_UPD_C: begin
        // c was read while b was written
        if (idx_c_r == idx_b_r) begin
          old_nrm = fwd_r;
        end
        nrm_we    = 1'b1;
        nrm_waddr = idx_c_r;
        nrm_wdata = new_nrm;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_ok_r ? nrm_rdata : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_a_r    <= idx_a_nxt;
    idx_b_r    <= idx_b_nxt;
    idx_c_r    <= idx_c_nxt;
    rd_ok_r    <= rd_ok_nxt;
    fwd_r      <= fwd_nxt;
    out_data_r <= out_data_nxt;
  end

  // vertex position memory
  tvna_ram #(
    .WIDTH (POS_WORD_W),
    .DEPTH (VERTEX_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // vertex normal memory
  tvna_ram #(
    .WIDTH (NRM_WORD_W),
    .DEPTH (VERTEX_COUNT)
  ) u_nrm_ram (
    .clk   (clk),
    .we    (nrm_we),
    .waddr (nrm_waddr),
    .wdata (nrm_wdata),
    .re    (nrm_re),
    .raddr (nrm_raddr),
    .rdata (nrm_rdata)
  );

  // face normal datapath
  tvna_face u_face (
    .clk       (clk),
    .ctl       (ctl),
    .pos_rdata (pos_rdata),
    .face_x    (face_x),
    .face_y    (face_y),
    .face_z    (face_z)
  );

  assign out_valid    = out_valid_r;
  assign out_normal_x = out_data_r[NORM_W-1:0];
  assign out_normal_y = out_data_r[2*NORM_W-1:NORM_W];
  assign out_normal_z = out_data_r[3*NORM_W-1:2*NORM_W];

endmodule

`default_nettype wire
